>>> hw/rtl/mmp_pkg.sv
// Shared types, constants and the byte classifier for the MIDI message parser.
package mmp_pkg;

    // Depth of the queue between the classifying front and the executing back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // MIDI byte values that the parser recognises.
    localparam logic [7:0] SYS_MASK      = 8'hF0;
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [7:0] RT_CLOCK      = 8'hF8;
    localparam logic [7:0] RT_START      = 8'hFA;
    localparam logic [7:0] RT_CONTINUE   = 8'hFB;
    localparam logic [7:0] RT_STOP       = 8'hFC;
    localparam logic [3:0] HI_PROG_CHG   = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;

    // Class of a received byte, decided by the front.
    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_STATUS,
        CLS_REALTIME,
        CLS_SYSEX_START,
        CLS_SYSEX_END,
        CLS_IGNORE
    } t_byte_class;

    // Kind of result given for each byte.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_REALTIME = 2'd1,
        EV_MESSAGE  = 2'd2
    } t_event_kind;

    // One queued request: the byte and its class.
    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  rx_byte;
    } t_queue_entry;

    // Sorts a byte into its class.
    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        if ((b & SYS_MASK) == SYS_MASK) begin
            if (b == RT_CLOCK || b == RT_START || b == RT_CONTINUE || b == RT_STOP) begin
                c = CLS_REALTIME;
            end else if (b == SYSEX_START) begin
                c = CLS_SYSEX_START;
            end else if (b == SYSEX_END) begin
                c = CLS_SYSEX_END;
            end else begin
                c = CLS_IGNORE;
            end
        end else if (b[7]) begin
            c = CLS_STATUS;
        end else begin
            c = CLS_DATA;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/mmp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
interface mmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mmp_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, output event_kind, output status_byte,
                    output first_data, output second_data, input ready);
    modport sink   (input valid, input event_kind, input status_byte,
                    input first_data, input second_data, output ready);
endinterface

>>> hw/rtl/mmp_front.sv
// Front part: accepts received bytes and classifies them for the queue.
module mmp_front
    import mmp_pkg::*;
(
    mmp_byte_if.sink      i_byte,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output t_queue_entry  o_push_data
);

    // A request is accepted whenever the queue has room.
    assign i_byte.ready = i_push_ready;
    assign o_push_valid = i_byte.valid;

    // Attach the byte's class so that the back needs only a small decode.
    always_comb begin
        o_push_data.cls     = classify(i_byte.rx_byte);
        o_push_data.rx_byte = i_byte.rx_byte;
    end

endmodule

>>> hw/rtl/mmp_queue.sv
// Short queue of classified requests between the front and the back.
module mmp_queue
    import mmp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  t_queue_entry  i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output t_queue_entry  o_pop_data
);

    t_queue_entry            r_entries [QDEPTH];
    logic [QPTR_W-1:0]       r_wr_ptr;
    logic [QPTR_W-1:0]       r_rd_ptr;
    logic [QCNT_W-1:0]       r_count;
    logic                    push;
    logic                    pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_entries[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> hw/rtl/mmp_back.sv
// Back part: applies each classified byte to the running state and registers the result.
module mmp_back
    import mmp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  t_queue_entry  i_pop_data,
    mmp_event_if.source   o_event
);

    // Parser state.
    logic [7:0]   r_running_status;
    logic         r_need_two;
    logic         r_have_first;
    logic [6:0]   r_held_first;
    logic         r_inside_sysex;
    logic [7:0]   n_running_status;
    logic         n_need_two;
    logic         n_have_first;
    logic [6:0]   n_held_first;
    logic         n_inside_sysex;

    // Output register.
    logic         r_out_valid;
    t_event_kind  r_kind;
    logic [7:0]   r_status;
    logic [6:0]   r_d1;
    logic [6:0]   r_d2;
    t_event_kind  n_kind;
    logic [7:0]   n_status;
    logic [6:0]   n_d1;
    logic [6:0]   n_d2;

    logic         pop;
    logic [7:0]   b;

    assign o_pop_ready = !r_out_valid || o_event.ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign b           = i_pop_data.rx_byte;

    // Next state and result for the request at the head of the queue.
    always_comb begin
        n_running_status = r_running_status;
        n_need_two       = r_need_two;
        n_have_first     = r_have_first;
        n_held_first     = r_held_first;
        n_inside_sysex   = r_inside_sysex;
        n_kind           = EV_NONE;
        n_status         = '0;
        n_d1             = '0;
        n_d2             = '0;
        unique case (i_pop_data.cls)
            CLS_REALTIME: begin
                n_kind   = EV_REALTIME;
                n_status = b;
            end
            CLS_SYSEX_START: begin
                n_inside_sysex = 1'b1;
            end
            CLS_SYSEX_END: begin
                n_inside_sysex = 1'b0;
            end
            CLS_STATUS: begin
                n_inside_sysex   = 1'b0;
                n_have_first     = 1'b0;
                n_running_status = b;
                n_need_two       = !(b[7:4] == HI_PROG_CHG || b[7:4] == HI_CHAN_PRESS);
            end
            CLS_DATA: begin
                if (!r_inside_sysex && r_running_status != '0) begin
                    if (!r_have_first) begin
                        n_held_first = b[6:0];
                        if (r_need_two) begin
                            n_have_first = 1'b1;
                        end else begin
                            n_kind   = EV_MESSAGE;
                            n_status = r_running_status;
                            n_d1     = b[6:0];
                        end
                    end else begin
                        n_have_first = 1'b0;
                        n_kind       = EV_MESSAGE;
                        n_status     = r_running_status;
                        n_d1         = r_held_first;
                        n_d2         = b[6:0];
                    end
                end
            end
            default: begin
                // Ignored system bytes leave everything as it is.
            end
        endcase
    end

    // State and output control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= '0;
            r_need_two       <= 1'b0;
            r_have_first     <= 1'b0;
            r_held_first     <= '0;
            r_inside_sysex   <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (pop) begin
                r_running_status <= n_running_status;
                r_need_two       <= n_need_two;
                r_have_first     <= n_have_first;
                r_held_first     <= n_held_first;
                r_inside_sysex   <= n_inside_sysex;
                r_out_valid      <= 1'b1;
            end else if (o_event.ready) begin
                r_out_valid      <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_d1     <= n_d1;
            r_d2     <= n_d2;
        end
    end

    assign o_event.valid       = r_out_valid;
    assign o_event.event_kind  = r_kind;
    assign o_event.status_byte = r_status;
    assign o_event.first_data  = r_d1;
    assign o_event.second_data = r_d2;

endmodule

>>> hw/rtl/midi_message_parser.sv
// Top level of the MIDI running-status message parser.
//
// The input channel carries one received MIDI byte per request; the output
// channel gives exactly one result per byte: event kind, status byte and up to
// two data bytes. Realtime bytes come straight out, channel messages come out
// when their last data byte arrives, and every other byte gives an empty result.
// Running status is kept, so data bytes after a complete message start the next.
//
// The front classifies each byte, a two-entry queue holds the classified
// requests, and the back updates the running state and fills an output register.
// An accepted byte is first registered in the queue, and its result is then
// registered in the output register. One byte is taken every cycle while the
// receiver keeps ready high; the rate is set by the state update in the back.
//
// Reset clears the running status, the data count and the sysex flag, and
// empties the queue and the output register. When the receiver stalls, the
// result waits in the output register and the queue fills; input ready drops
// only once both queue entries are taken.
module midi_message_parser
    import mmp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmp_byte_if.sink      i_byte,
    mmp_event_if.source   o_event
);

    logic          push_valid;
    logic          push_ready;
    t_queue_entry  push_data;
    logic          pop_valid;
    logic          pop_ready;
    t_queue_entry  pop_data;

    // Accept and classify.
    mmp_front u_front (
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Decoupling queue.
    mmp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Execute and register the result.
    mmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_event     (o_event)
    );

endmodule
